FILE: rtl/kts_pkg.sv
// kts_pkg: shared constants for the keyword token scanner
// token kind codes, keyword spelling table and default widths
// no dependencies
package kts_pkg;

   // default widths of the position and length fields
   localparam int OFFSET_BITS_DEF = 24;
   localparam int LINE_BITS_DEF   = 16;
   localparam int LENGTH_BITS_DEF = 8;

   // fixed payload widths
   localparam int KIND_BITS = 6;
   localparam int NUM_BITS  = 31;
   localparam int KW_COUNT  = 14;

   typedef logic [KIND_BITS-1:0] kind_type;

   // token kinds, keywords take codes 0 to 13 by table index
   localparam kind_type KIND_ID     = 6'd14;
   localparam kind_type KIND_NUM    = 6'd15;
   localparam kind_type KIND_ASSIGN = 6'd16;
   localparam kind_type KIND_PLUS   = 6'd17;
   localparam kind_type KIND_MINUS  = 6'd18;
   localparam kind_type KIND_MULT   = 6'd19;
   localparam kind_type KIND_DIV    = 6'd20;
   localparam kind_type KIND_EQ     = 6'd21;
   localparam kind_type KIND_NEQ    = 6'd22;
   localparam kind_type KIND_LT     = 6'd23;
   localparam kind_type KIND_GT     = 6'd24;
   localparam kind_type KIND_LTE    = 6'd25;
   localparam kind_type KIND_GTE    = 6'd26;
   localparam kind_type KIND_LPAREN = 6'd27;
   localparam kind_type KIND_RPAREN = 6'd28;
   localparam kind_type KIND_SEMI   = 6'd29;
   localparam kind_type KIND_COMMA  = 6'd30;
   localparam kind_type KIND_COLON  = 6'd31;
   localparam kind_type KIND_DOT    = 6'd32;
   localparam kind_type KIND_EOF    = 6'd33;
   localparam kind_type KIND_ERROR  = 6'd34;

   // saturation value of number tokens
   localparam logic [NUM_BITS-1:0] NUM_MAX = '1;

   // keyword spellings, right aligned, first character in the highest used byte
   localparam logic [63:0] KW_TEXT [KW_COUNT] = '{
      "program", "var", "integer", "begin", "end", "if", "then",
      "else", "while", "do", "repeat", "until", "read", "output"
   };
   localparam logic [2:0] KW_LEN [KW_COUNT] = '{
      3'd7, 3'd3, 3'd7, 3'd5, 3'd3, 3'd2, 3'd4,
      3'd4, 3'd5, 3'd2, 3'd6, 3'd5, 3'd4, 3'd6
   };

   // character of keyword k at position pos, valid when pos is below its length
   function automatic logic [7:0] kw_char(input logic [3:0] k, input logic [2:0] pos);
      logic [2:0] idx;
      idx = KW_LEN[k] - 3'd1 - pos;
      return KW_TEXT[k][{idx, 3'b000} +: 8];
   endfunction

endpackage

FILE: rtl/keyword_token_scanner_core.sv
// keyword_token_scanner_core: byte-wide lexer for a small pascal-like language
// scan state, token decode and a two-entry result queue
// depends on kts_pkg
//
//   channel | direction | handshake         | payload
//   --------+-----------+-------------------+------------------------------------------
//   req     | in        | req_valid/stall   | ch, end_of_text
//   rsp     | out       | rsp_valid/stall   | token_kind, token_line, token_start,
//           |           |                   | token_length, number_value, last
//
// one request is taken per cycle while req_stall is low; its tokens are decoded from
// the scan state in the same cycle and written into a two-entry queue, each entry
// holding all tokens of one request, so the tokens are registered before they reach rsp.
// a request that yields two tokens shows them on rsp in turn, with rsp_last on the second.
// req_stall is high while both queue entries are occupied.
// reset is synchronous and returns the scanner to line 1, offset 0, empty queue.
module keyword_token_scanner_core #(
   parameter int OFFSET_BITS = kts_pkg::OFFSET_BITS_DEF,
   parameter int LINE_BITS   = kts_pkg::LINE_BITS_DEF,
   parameter int LENGTH_BITS = kts_pkg::LENGTH_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [7:0]                     req_ch,
   input  logic                           req_end_of_text,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic [kts_pkg::KIND_BITS-1:0]  rsp_token_kind,
   output logic [LINE_BITS-1:0]           rsp_token_line,
   output logic [OFFSET_BITS-1:0]         rsp_token_start,
   output logic [LENGTH_BITS-1:0]         rsp_token_length,
   output logic [kts_pkg::NUM_BITS-1:0]   rsp_number_value,
   output logic                           rsp_last
);
   import kts_pkg::*;

   // carriage return has no plain string escape
   localparam logic [7:0] CH_CR = 8'h0D;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_COMMENT, MODE_IDENT, MODE_NUMBER,
      MODE_LT, MODE_GT, MODE_COLON, MODE_STOPPED, MODE_DONE
   } mode_type;

   typedef struct packed {
      kind_type               kind;
      logic [LINE_BITS-1:0]   line;
      logic [OFFSET_BITS-1:0] start;
      logic [LENGTH_BITS-1:0] length;
      logic [NUM_BITS-1:0]    value;
   } token_type;

   typedef struct packed {
      token_type first;
      token_type second;
      logic      pair;
   } entry_type;

   function automatic token_type make_token(input kind_type kind,
                                            input logic [OFFSET_BITS-1:0] start,
                                            input logic [LENGTH_BITS-1:0] length,
                                            input logic [NUM_BITS-1:0] value,
                                            input logic [LINE_BITS-1:0] line);
      token_type t;
      t.kind   = kind;
      t.line   = line;
      t.start  = start;
      t.length = length;
      t.value  = value;
      return t;
   endfunction

   // scan state
   mode_type               mode_ff, mode_in;
   logic [KW_COUNT-1:0]    cand_ff, cand_in;
   logic [LENGTH_BITS-1:0] len_ff, len_in;
   logic [OFFSET_BITS-1:0] start_ff, start_in;
   logic [NUM_BITS-1:0]    acc_ff, acc_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [OFFSET_BITS-1:0] offset_ff, offset_in;

   // result queue
   entry_type              entry_ff [2];
   logic                   wr_ptr_ff, rd_ptr_ff, slot_ff;
   logic [1:0]             count_ff, count_in;

   logic                   req_accept, push, pop, rsp_take;
   logic                   is_letter, is_digit, is_word;
   logic [LINE_BITS-1:0]   line_inc;
   logic [LENGTH_BITS-1:0] len_inc;
   logic [KW_COUNT-1:0]    cand_first, cand_cont;
   logic [NUM_BITS+3:0]    num_prod;
   logic [NUM_BITS-1:0]    num_next;
   kind_type               kw_kind, idle_kind, pair_kind;
   logic                   flush_hit, idle_hit, pair_op, restart;
   token_type              flush_tok, idle_tok, pair_tok, eof_tok;
   mode_type               idle_mode;
   logic [LINE_BITS-1:0]   idle_line;
   logic [KW_COUNT-1:0]    idle_cand;
   logic [NUM_BITS-1:0]    idle_acc;
   logic                   first_hit, second_hit;
   token_type              first_tok, second_tok;
   entry_type              entry_in, head;

   assign req_stall  = (count_ff == 2'd2);
   assign req_accept = req_valid && !req_stall;

   // character classes
   assign is_letter = (req_ch >= "a" && req_ch <= "z") || (req_ch >= "A" && req_ch <= "Z");
   assign is_digit  = (req_ch >= "0" && req_ch <= "9");
   assign is_word   = is_letter || is_digit || (req_ch == "_");

   // saturating counters
   assign line_inc = (line_ff == '1) ? line_ff : line_ff + 1'b1;
   assign len_inc  = (len_ff == '1) ? len_ff : len_ff + 1'b1;

   // keyword candidate filters for the first and the following characters
   always_comb begin
      for (int k = 0; k < KW_COUNT; k++) begin
         cand_first[k] = (kw_char(4'(k), 3'd0) == req_ch);
         cand_cont[k]  = cand_ff[k] && (len_ff < LENGTH_BITS'(KW_LEN[k]))
                         && (kw_char(4'(k), len_ff[2:0]) == req_ch);
      end
   end

   // decimal accumulate with saturation
   assign num_prod = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                   + (NUM_BITS+4)'(req_ch[3:0]);
   assign num_next = (num_prod > (NUM_BITS+4)'(NUM_MAX)) ? NUM_MAX : num_prod[NUM_BITS-1:0];

   // token left pending by the current mode
   always_comb begin
      kw_kind = KIND_ID;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (cand_ff[k] && (len_ff == LENGTH_BITS'(KW_LEN[k]))) begin
            kw_kind = KIND_BITS'(k);
         end
      end
      flush_hit = 1'b0;
      flush_tok = make_token(kw_kind, start_ff, len_ff, '0, line_ff);
      unique case (mode_ff)
         MODE_IDENT: flush_hit = 1'b1;
         MODE_NUMBER: begin
            flush_hit = 1'b1;
            flush_tok = make_token(KIND_NUM, start_ff, len_ff, acc_ff, line_ff);
         end
         MODE_LT: begin
            flush_hit = 1'b1;
            flush_tok = make_token(KIND_LT, start_ff, LENGTH_BITS'(1), '0, line_ff);
         end
         MODE_GT: begin
            flush_hit = 1'b1;
            flush_tok = make_token(KIND_GT, start_ff, LENGTH_BITS'(1), '0, line_ff);
         end
         MODE_COLON: begin
            flush_hit = 1'b1;
            flush_tok = make_token(KIND_COLON, start_ff, LENGTH_BITS'(1), '0, line_ff);
         end
         default: ;
      endcase
   end

   // byte seen with no token open
   always_comb begin
      idle_hit  = 1'b0;
      idle_kind = KIND_ERROR;
      idle_mode = MODE_IDLE;
      idle_line = line_ff;
      idle_cand = cand_ff;
      idle_acc  = acc_ff;
      unique case (req_ch)
         " ", "\t", CH_CR: ;
         "\n": idle_line = line_inc;
         "{":  idle_mode = MODE_COMMENT;
         "+":  begin idle_hit = 1'b1; idle_kind = KIND_PLUS;   end
         "-":  begin idle_hit = 1'b1; idle_kind = KIND_MINUS;  end
         "*":  begin idle_hit = 1'b1; idle_kind = KIND_MULT;   end
         "/":  begin idle_hit = 1'b1; idle_kind = KIND_DIV;    end
         "=":  begin idle_hit = 1'b1; idle_kind = KIND_EQ;     end
         "(":  begin idle_hit = 1'b1; idle_kind = KIND_LPAREN; end
         ")":  begin idle_hit = 1'b1; idle_kind = KIND_RPAREN; end
         ";":  begin idle_hit = 1'b1; idle_kind = KIND_SEMI;   end
         ",":  begin idle_hit = 1'b1; idle_kind = KIND_COMMA;  end
         ".":  begin idle_hit = 1'b1; idle_kind = KIND_DOT;    end
         "<":  idle_mode = MODE_LT;
         ">":  idle_mode = MODE_GT;
         ":":  idle_mode = MODE_COLON;
         default: begin
            if (is_letter) begin
               idle_mode = MODE_IDENT;
               idle_cand = cand_first;
            end else if (is_digit) begin
               idle_mode = MODE_NUMBER;
               idle_acc  = NUM_BITS'(req_ch[3:0]);
            end else begin
               idle_hit  = 1'b1;
               idle_mode = MODE_STOPPED;
            end
         end
      endcase
      idle_tok = make_token(idle_kind, offset_ff, LENGTH_BITS'(1), '0, line_ff);
   end

   // two-character operators
   always_comb begin
      pair_op = (req_ch == "=") || (req_ch == ">" && mode_ff == MODE_LT);
      if (mode_ff == MODE_COLON) begin
         pair_kind = KIND_ASSIGN;
      end else if (mode_ff == MODE_GT) begin
         pair_kind = KIND_GTE;
      end else if (req_ch == "=") begin
         pair_kind = KIND_LTE;
      end else begin
         pair_kind = KIND_NEQ;
      end
      pair_tok = make_token(pair_kind, start_ff, LENGTH_BITS'(2), '0, line_ff);
   end

   assign eof_tok = make_token(KIND_EOF, offset_ff, '0, '0, line_ff);

   // next scan state and the tokens of this request
   always_comb begin
      mode_in    = mode_ff;
      cand_in    = cand_ff;
      len_in     = len_ff;
      start_in   = start_ff;
      acc_in     = acc_ff;
      line_in    = line_ff;
      offset_in  = offset_ff;
      first_hit  = 1'b0;
      second_hit = 1'b0;
      first_tok  = flush_tok;
      second_tok = idle_tok;
      restart    = 1'b0;
      if (mode_ff == MODE_STOPPED) begin
         // halted after an error
      end else if (mode_ff == MODE_DONE) begin
         if (req_end_of_text) begin
            second_hit = 1'b1;
            second_tok = eof_tok;
         end
      end else if (req_end_of_text) begin
         first_hit  = flush_hit;
         second_hit = 1'b1;
         second_tok = eof_tok;
         mode_in    = MODE_DONE;
      end else begin
         offset_in = offset_ff + 1'b1;
         unique case (mode_ff)
            MODE_COMMENT: begin
               if (req_ch == "\n") line_in = line_inc;
               if (req_ch == "}") mode_in = MODE_IDLE;
            end
            MODE_IDENT: begin
               if (is_word) begin
                  cand_in = cand_cont;
                  len_in  = len_inc;
               end else begin
                  restart = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_digit) begin
                  acc_in = num_next;
                  len_in = len_inc;
               end else begin
                  restart = 1'b1;
               end
            end
            MODE_LT, MODE_GT, MODE_COLON: begin
               if (pair_op) begin
                  second_hit = 1'b1;
                  second_tok = pair_tok;
                  mode_in    = MODE_IDLE;
               end else begin
                  restart = 1'b1;
               end
            end
            default: restart = 1'b1;
         endcase
         // close any open token and treat the byte as a fresh start
         if (restart) begin
            first_hit  = flush_hit;
            second_hit = idle_hit;
            second_tok = idle_tok;
            mode_in    = idle_mode;
            start_in   = offset_ff;
            len_in     = LENGTH_BITS'(1);
            line_in    = idle_line;
            cand_in    = idle_cand;
            acc_in     = idle_acc;
         end
      end
   end

   // queue entry for this request
   always_comb begin
      entry_in.first  = first_hit ? first_tok : second_tok;
      entry_in.second = second_tok;
      entry_in.pair   = first_hit && second_hit;
   end

   // queue control
   assign head      = entry_ff[rd_ptr_ff];
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_take  = rsp_valid && !rsp_stall;
   assign pop       = rsp_take && (slot_ff || !head.pair);
   assign push      = req_accept && (first_hit || second_hit);

   always_comb begin
      case ({push, pop})
         2'b10:   count_in = count_ff + 2'd1;
         2'b01:   count_in = count_ff - 2'd1;
         default: count_in = count_ff;
      endcase
   end

   // result port
   always_comb begin
      if (slot_ff) begin
         rsp_token_kind   = head.second.kind;
         rsp_token_line   = head.second.line;
         rsp_token_start  = head.second.start;
         rsp_token_length = head.second.length;
         rsp_number_value = head.second.value;
      end else begin
         rsp_token_kind   = head.first.kind;
         rsp_token_line   = head.first.line;
         rsp_token_start  = head.first.start;
         rsp_token_length = head.first.length;
         rsp_number_value = head.first.value;
      end
      rsp_last = slot_ff || !head.pair;
   end

   // scan state and queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         cand_ff   <= '1;
         len_ff    <= '0;
         start_ff  <= '0;
         acc_ff    <= '0;
         line_ff   <= LINE_BITS'(1);
         offset_ff <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         slot_ff   <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (req_accept) begin
            mode_ff   <= mode_in;
            cand_ff   <= cand_in;
            len_ff    <= len_in;
            start_ff  <= start_in;
            acc_ff    <= acc_in;
            line_ff   <= line_in;
            offset_ff <= offset_in;
         end
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
            slot_ff   <= 1'b0;
         end else if (rsp_take) begin
            slot_ff   <= 1'b1;
         end
         count_ff <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) entry_ff[wr_ptr_ff] <= entry_in;
   end

   // queue never holds more than two requests
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   // second half is only read from a non-empty entry that holds two tokens
   a_slot_pair: assert property (@(posedge clock) disable iff (reset)
      slot_ff |-> (count_ff != 2'd0 && head.pair))
      else $error("second token read from a single-token entry");

   // error halt is permanent until reset
   a_stop_sticky: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_STOPPED |=> mode_ff == MODE_STOPPED)
      else $error("scanner left the stopped mode");

   // a halted scanner adds nothing to the queue
   a_stop_silent: assert property (@(posedge clock) disable iff (reset)
      (req_accept && mode_ff == MODE_STOPPED) |=> count_ff <= $past(count_ff))
      else $error("token queued after error halt");

   // line number never goes back
   a_line_mono: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> line_ff >= $past(line_ff))
      else $error("line count decreased");

endmodule

FILE: test/token_ledger_pkg.sv
// token_ledger_pkg: predicted token stream of the keyword token scanner
// one class mirrors the scan state and holds the tokens still due on rsp
// depends on kts_pkg
package token_ledger_pkg;
   import kts_pkg::*;

   localparam int OFS_W  = OFFSET_BITS_DEF;
   localparam int LINE_W = LINE_BITS_DEF;
   localparam int LEN_W  = LENGTH_BITS_DEF;

   // control characters that have no plain string escape
   localparam logic [7:0] CH_TAB = 8'h09;
   localparam logic [7:0] CH_LF  = 8'h0A;
   localparam logic [7:0] CH_CR  = 8'h0D;

   typedef enum logic [3:0] {
      MODE_IDLE, MODE_COMMENT, MODE_IDENT, MODE_NUMBER, MODE_AFTER_LT,
      MODE_AFTER_GT, MODE_AFTER_COLON, MODE_STOPPED, MODE_DONE
   } scan_mode_e;

   typedef struct {
      kind_type             kind;
      logic [LINE_W-1:0]    line;
      logic [OFS_W-1:0]     start;
      logic [LEN_W-1:0]     length;
      logic [NUM_BITS-1:0]  value;
      logic                 last;
   } token_rec;

   class token_ledger;
      string               words [KW_COUNT];
      scan_mode_e          mode;
      logic [KW_COUNT-1:0] kw_live;
      logic [LEN_W-1:0]    tok_len;
      logic [OFS_W-1:0]    tok_start;
      logic [NUM_BITS-1:0] num_acc;
      logic [LINE_W-1:0]   line_no;
      logic [OFS_W-1:0]    offset;
      token_rec            pending_tokens [$];
      token_rec            step_tokens [$];
      int                  errors;
      int                  checked;

      function new();
         words = '{"program", "var", "integer", "begin", "end", "if", "then",
                   "else", "while", "do", "repeat", "until", "read", "output"};
         mode      = MODE_IDLE;
         kw_live   = '1;
         tok_len   = '0;
         tok_start = '0;
         num_acc   = '0;
         line_no   = LINE_W'(1);
         offset    = '0;
         errors    = 0;
         checked   = 0;
      endfunction

      function int pending();
         return pending_tokens.size();
      endfunction

      function void report(string what);
         $display("mismatch: %s", what);
         errors++;
      endfunction

      function bit is_letter(logic [7:0] c);
         return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      endfunction

      function bit is_digit(logic [7:0] c);
         return c >= "0" && c <= "9";
      endfunction

      function void bump_line();
         if (line_no != '1) line_no++;
      endfunction

      function void add_token(kind_type kind, logic [OFS_W-1:0] start,
                              logic [LEN_W-1:0] len, logic [NUM_BITS-1:0] value);
         token_rec t;
         t.kind   = kind;
         t.line   = line_no;
         t.start  = start;
         t.length = len;
         t.value  = value;
         t.last   = 1'b0;
         step_tokens = {step_tokens, t};
      endfunction

      // drop every keyword whose character at this position differs
      function void narrow_keywords(logic [7:0] c, logic [LEN_W-1:0] position);
         bit keep;
         for (int k = 0; k < KW_COUNT; k++) begin
            keep = 1'b0;
            if (int'(position) < words[k].len()) keep = (words[k][int'(position)] == c);
            if (!keep) kw_live[k] = 1'b0;
         end
      endfunction

      // emit whatever token the current mode holds
      function void flush_token();
         kind_type kind;
         case (mode)
            MODE_IDENT: begin
               kind = KIND_ID;
               for (int k = 0; k < KW_COUNT; k++)
                  if (kw_live[k] && words[k].len() == int'(tok_len)) kind = kind_type'(k);
               add_token(kind, tok_start, tok_len, '0);
            end
            MODE_NUMBER:      add_token(KIND_NUM, tok_start, tok_len, num_acc);
            MODE_AFTER_LT:    add_token(KIND_LT, tok_start, LEN_W'(1), '0);
            MODE_AFTER_GT:    add_token(KIND_GT, tok_start, LEN_W'(1), '0);
            MODE_AFTER_COLON: add_token(KIND_COLON, tok_start, LEN_W'(1), '0);
            default: ;
         endcase
         mode = MODE_IDLE;
      endfunction

      // byte seen with no token open
      function void start_token(logic [7:0] c, logic [OFS_W-1:0] pos);
         tok_start = pos;
         tok_len   = LEN_W'(1);
         case (c)
            " ", CH_TAB, CH_CR: ;
            CH_LF: bump_line();
            "{": mode = MODE_COMMENT;
            "+": add_token(KIND_PLUS, pos, LEN_W'(1), '0);
            "-": add_token(KIND_MINUS, pos, LEN_W'(1), '0);
            "*": add_token(KIND_MULT, pos, LEN_W'(1), '0);
            "/": add_token(KIND_DIV, pos, LEN_W'(1), '0);
            "=": add_token(KIND_EQ, pos, LEN_W'(1), '0);
            "(": add_token(KIND_LPAREN, pos, LEN_W'(1), '0);
            ")": add_token(KIND_RPAREN, pos, LEN_W'(1), '0);
            ";": add_token(KIND_SEMI, pos, LEN_W'(1), '0);
            ",": add_token(KIND_COMMA, pos, LEN_W'(1), '0);
            ".": add_token(KIND_DOT, pos, LEN_W'(1), '0);
            "<": mode = MODE_AFTER_LT;
            ">": mode = MODE_AFTER_GT;
            ":": mode = MODE_AFTER_COLON;
            default: begin
               if (is_letter(c)) begin
                  mode    = MODE_IDENT;
                  kw_live = '1;
                  narrow_keywords(c, '0);
               end else if (is_digit(c)) begin
                  mode    = MODE_NUMBER;
                  num_acc = NUM_BITS'(c - "0");
               end else begin
                  add_token(KIND_ERROR, pos, LEN_W'(1), '0);
                  mode = MODE_STOPPED;
               end
            end
         endcase
      endfunction

      // advance the scan by one accepted request and queue its tokens
      function void scan_byte(logic [7:0] c, logic eot);
         logic [OFS_W-1:0] pos;
         logic [63:0]      grown;
         pos = offset;
         step_tokens.delete();
         if (mode == MODE_STOPPED) return;
         if (mode == MODE_DONE) begin
            if (eot) add_token(KIND_EOF, pos, '0, '0);
         end else if (eot) begin
            flush_token();
            add_token(KIND_EOF, pos, '0, '0);
            mode = MODE_DONE;
         end else begin
            case (mode)
               MODE_COMMENT: begin
                  if (c == CH_LF) bump_line();
                  if (c == "}") mode = MODE_IDLE;
               end
               MODE_IDENT: begin
                  if (is_letter(c) || is_digit(c) || c == "_") begin
                     narrow_keywords(c, tok_len);
                     if (tok_len != '1) tok_len++;
                  end else begin
                     flush_token();
                     start_token(c, pos);
                  end
               end
               MODE_NUMBER: begin
                  if (is_digit(c)) begin
                     grown = 64'(num_acc) * 64'd10 + 64'(c) - 64'd48;
                     num_acc = (grown > 64'(NUM_MAX)) ? NUM_MAX : grown[NUM_BITS-1:0];
                     if (tok_len != '1) tok_len++;
                  end else begin
                     flush_token();
                     start_token(c, pos);
                  end
               end
               MODE_AFTER_LT, MODE_AFTER_GT, MODE_AFTER_COLON: begin
                  if (c == "=" || (c == ">" && mode == MODE_AFTER_LT)) begin
                     add_token(mode == MODE_AFTER_COLON ? KIND_ASSIGN :
                               mode == MODE_AFTER_GT    ? KIND_GTE    :
                               c == "="                 ? KIND_LTE    : KIND_NEQ,
                               tok_start, LEN_W'(2), '0);
                     mode = MODE_IDLE;
                  end else begin
                     flush_token();
                     start_token(c, pos);
                  end
               end
               default: start_token(c, pos);
            endcase
            offset = pos + 1'b1;
         end
         if (step_tokens.size() > 0) step_tokens[step_tokens.size()-1].last = 1'b1;
         foreach (step_tokens[i]) pending_tokens = {pending_tokens, step_tokens[i]};
      endfunction

      function void compare_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want)
            report($sformatf("token %0d %s: got %0d, expected %0d", checked, name, got, want));
      endfunction

      // compare one token taken from rsp with the oldest one due
      function void match_token(token_rec got);
         token_rec want;
         if (pending_tokens.size() == 0) begin
            report($sformatf("token %0d kind %0d arrived with none due", checked, got.kind));
         end else begin
            want = pending_tokens.pop_front();
            compare_field("kind", 32'(got.kind), 32'(want.kind));
            compare_field("line", 32'(got.line), 32'(want.line));
            compare_field("start", 32'(got.start), 32'(want.start));
            compare_field("length", 32'(got.length), 32'(want.length));
            compare_field("value", 32'(got.value), 32'(want.value));
            compare_field("last", 32'(got.last), 32'(want.last));
         end
         checked++;
      endfunction

      function void final_check();
         if (pending_tokens.size() != 0)
            report($sformatf("%0d tokens never arrived", pending_tokens.size()));
      endfunction
   endclass

endpackage

FILE: test/tb.sv
// tb: feeds source text into keyword_token_scanner_core and checks every token
// directed text, then random well-formed fragments with idle and stall bursts
// depends on kts_pkg, token_ledger_pkg and the scanner rtl
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import kts_pkg::*;
   import token_ledger_pkg::*;

   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_CYCLES = 16;

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [7:0]           req_ch;
   logic                 req_end_of_text;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [KIND_BITS-1:0] rsp_token_kind;
   logic [LINE_W-1:0]    rsp_token_line;
   logic [OFS_W-1:0]     rsp_token_start;
   logic [LEN_W-1:0]     rsp_token_length;
   logic [NUM_BITS-1:0]  rsp_number_value;
   logic                 rsp_last;

   token_ledger ledger = new();
   bit          quiet = 1'b0;
   bit          hold_off_go = 1'b0;
   int          bytes_sent = 0;

   keyword_token_scanner_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_ch           (req_ch),
      .req_end_of_text  (req_end_of_text),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_token_kind   (rsp_token_kind),
      .rsp_token_line   (rsp_token_line),
      .rsp_token_start  (rsp_token_start),
      .rsp_token_length (rsp_token_length),
      .rsp_number_value (rsp_number_value),
      .rsp_last         (rsp_last)
   );

   // 12 ns clock
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // give up long after the slowest correct run
   initial begin
      #5_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

   // random characters of the source language
   function automatic logic [7:0] letter();
      if ($urandom_range(0, 3) != 0) return 8'("a" + $urandom_range(0, 25));
      return 8'("A" + $urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] digit();
      return 8'("0" + $urandom_range(0, 9));
   endfunction

   function automatic logic [7:0] ident_char();
      case ($urandom_range(0, 5))
         0, 1, 2, 3: return letter();
         4:          return digit();
         default:    return "_";
      endcase
   endfunction

   function automatic logic [7:0] blank();
      case ($urandom_range(0, 3))
         0:       return " ";
         1:       return CH_TAB;
         2:       return CH_CR;
         default: return CH_LF;
      endcase
   endfunction

   // byte that cannot open a token
   function automatic logic [7:0] bad_byte();
      string odd;
      odd = "_!#$%&?@[]^`|~}";
      case ($urandom_range(0, 2))
         0:       return 8'($urandom_range(128, 255));
         1:       return 8'($urandom_range(0, 8));
         default: return odd[$urandom_range(0, odd.len() - 1)];
      endcase
   endfunction

   // offer one request, wait until it is taken
   task automatic send_byte(input logic [7:0] c, input logic eot);
      if (!quiet && $urandom_range(0, 4) == 0) begin
         req_valid = 1'b0;
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
      req_valid       = 1'b1;
      req_ch          = c;
      req_end_of_text = eot;
      do @(posedge clock); while (req_stall);
      ledger.scan_byte(c, eot);
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_text(input string s);
      for (int i = 0; i < s.len(); i++) send_byte(s[i], 1'b0);
   endtask

   // one random piece of source text
   task automatic send_fragment();
      string      w;
      int         n;
      logic [7:0] b;
      case ($urandom_range(0, 9))
         0, 1: send_text(ledger.words[$urandom_range(0, KW_COUNT - 1)]);
         2: begin
            // near misses of a keyword
            w = ledger.words[$urandom_range(0, KW_COUNT - 1)];
            case ($urandom_range(0, 2))
               0: send_text(w.substr(0, w.len() - 2));
               1: begin
                  send_text(w);
                  repeat ($urandom_range(1, 3)) send_byte(ident_char(), 1'b0);
               end
               default: send_text(w.toupper());
            endcase
         end
         3: begin
            send_byte(letter(), 1'b0);
            repeat ($urandom_range(0, 7)) send_byte(ident_char(), 1'b0);
         end
         4: begin
            n = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
            repeat (n) send_byte(digit(), 1'b0);
         end
         5: begin
            w = "+-*/=();,.";
            send_byte(w[$urandom_range(0, w.len() - 1)], 1'b0);
         end
         6: begin
            // relational and assign operators, whole or broken
            w = "<>:";
            send_byte(w[$urandom_range(0, w.len() - 1)], 1'b0);
            w = "=><: a1";
            if ($urandom_range(0, 3) != 0) send_byte(w[$urandom_range(0, w.len() - 1)], 1'b0);
         end
         7: repeat ($urandom_range(1, 3)) send_byte(blank(), 1'b0);
         8: begin
            send_byte("{", 1'b0);
            repeat ($urandom_range(0, 6)) begin
               b = 8'($urandom_range(0, 255));
               if (b == "}") b = CH_LF;
               send_byte(b, 1'b0);
            end
            send_byte("}", 1'b0);
         end
         default: send_byte(" ", 1'b0);
      endcase
   endtask

   // receiver: stall bursts, one long hold-off, none at the end
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_go) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_off_go = 1'b0;
         end
         if (!quiet && $urandom_range(0, 3) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(1, 6) - 1) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
            if (!quiet) repeat ($urandom_range(0, 8)) @(negedge clock);
         end
      end
   end

   // token monitor
   always @(posedge clock) begin
      token_rec got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.kind   = rsp_token_kind;
         got.line   = rsp_token_line;
         got.start  = rsp_token_start;
         got.length = rsp_token_length;
         got.value  = rsp_number_value;
         got.last   = rsp_last;
         ledger.match_token(got);
      end
   end

   // request stimulus
   initial begin
      int frags;
      int long_ident_at;
      int long_number_at;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_ch          = '0;
      req_end_of_text = 1'b0;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      // directed: keyword, ident, two-byte operators, comment with a high byte
      send_text("if a1<=9{");
      send_byte(8'hFF, 1'b0);
      send_byte("}", 1'b0);
      send_byte(CH_LF, 1'b0);
      send_text("b:=7>=c<>d;");

      // random text, the receiver holds off first so the queue fills up
      hold_off_go    = 1'b1;
      long_ident_at  = $urandom_range(3, 40);
      long_number_at = $urandom_range(3, 40);
      frags          = 0;
      while (bytes_sent < 480) begin
         if (frags == long_ident_at) begin
            send_byte(" ", 1'b0);
            send_byte(letter(), 1'b0);
            repeat ($urandom_range(254, 261)) send_byte(ident_char(), 1'b0);
         end
         if (frags == long_number_at) begin
            send_byte(" ", 1'b0);
            repeat ($urandom_range(255, 262)) send_byte(digit(), 1'b0);
         end
         send_fragment();
         frags++;
      end

      // no idling from here on
      quiet = 1'b1;
      repeat (20) send_fragment();

      if ($urandom_range(0, 1) == 1) begin
         // end of text, maybe inside an open comment, then repeats and ignored bytes
         if ($urandom_range(0, 1) == 1) send_text("{ open");
         send_byte(8'($urandom_range(0, 255)), 1'b1);
         repeat (2) send_byte(8'($urandom_range(0, 255)), 1'b1);
         repeat (4) send_byte(8'($urandom_range(0, 255)), 1'b0);
         send_byte(8'($urandom_range(0, 255)), 1'b1);
      end else begin
         // unexpected byte stops the scanner for good
         send_byte(bad_byte(), 1'b0);
         repeat (3) send_byte(8'($urandom_range(0, 255)), 1'b0);
         send_byte(8'($urandom_range(0, 255)), 1'b1);
      end
      req_valid = 1'b0;

      // drain
      while (ledger.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      ledger.final_check();
      if (ledger.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
